[design/skc_pkg.sv]
`default_nettype none
package skc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int LOG_TABLE_BITS = 10;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ROOT_COUNT     = 16;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [13:0] LOG2_PER_DB = 14'd10885;

  localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
  localparam logic signed [15:0] GATE_RESET      = -16'sd15360;
  localparam logic [16:0]        INV_RATIO_RESET = 17'd32768;
  localparam logic signed [15:0] GAIN_RESET      = -16'sd2560;

  typedef enum logic [2:0] {
    REG_THRESHOLD,
    REG_GATE,
    REG_INV_RATIO,
    REG_KNEE_WIDTH,
    REG_KNEE_SCALE,
    REG_ATTACK,
    REG_RELEASE,
    REG_COUPLING
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic signed [15:0]            coupling_gain_db;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic signed [15:0]            gain_db;
    logic                          gated;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic signed [15:0] gate_threshold_db;
    logic [16:0]        inv_ratio;
    logic [13:0]        knee_width_db;
    logic [15:0]        knee_scale;
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic [16:0]        coupling_weight;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] level;
    in_item_t           item;
  } q_item_t;

  typedef logic [31:0] root_tab_t [ROOT_COUNT];

  function automatic logic [SAMPLE_BITS-1:0] abs_sample(input logic signed [SAMPLE_BITS-1:0] x);
    logic [SAMPLE_BITS-1:0] u;
    u = $unsigned(x);
    return x[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - u) : u;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bm;
    v   = v_in;
    res = 64'd0;
    bm  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bm) begin
        v   = v - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  // Q30 roots 2^(2^-(k+1)): the first the floor root of 2, each later one the floor root of the one before
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = isqrt64(64'h2000_0000_0000_0000);
    for (int k = 0; k < ROOT_COUNT; k++) begin
      tab[k] = root[31:0];
      root   = isqrt64(root << 30);
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

endpackage
`default_nettype wire

[design/skc_front.sv]
`default_nettype none
module skc_front #(
  parameter int LOG_TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  skc_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output skc_pkg::q_item_t  push_data
);
  import skc_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int LZ_W   = $clog2(SB);
  localparam int NEG_W  = LZ_W + 16;
  localparam int PROD_W = NEG_W + 19;
  localparam int RND_W  = PROD_W - 24;
  localparam int Y_W    = 31;

  typedef enum logic [2:0] {F_IDLE, F_NORM, F_SQ, F_MUL, F_PUSH} state_t;

  state_t                  state_r;
  in_item_t                item_r;
  logic [SB-1:0]           norm_r [2];
  logic [LZ_W-1:0]         lz_r   [2];
  logic [1:0]              zero_r;
  logic [Y_W-1:0]          y_r    [2];
  logic [15:0]             frac_r [2];
  logic [3:0]              cnt_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    silent_r;

  logic [SB-1:0]           abs_in    [2];
  logic [1:0]              lane_done;
  logic [SB-1:0]           norm_step [2];
  logic [LZ_W-1:0]         lz_step   [2];
  logic [Y_W-1:0]          y_init    [2];
  logic [61:0]             sq        [2];
  logic [31:0]             yy        [2];
  logic [NEG_W-1:0]        neg       [2];
  logic [NEG_W-1:0]        neg_sel;
  logic [PROD_W-1:0]       rnd_sum;
  logic [RND_W-1:0]        rounded;
  logic [16:0]             mag;

  always_comb begin
    abs_in[0] = abs_sample(in_data.left_sample);
    abs_in[1] = abs_sample(in_data.right_sample);
    for (int l = 0; l < 2; l++) begin
      lane_done[l] = zero_r[l] | norm_r[l][SB-1];
      if (norm_r[l][SB-1 -: 4] == 4'd0) begin
        norm_step[l] = norm_r[l] << 4;
        lz_step[l]   = lz_r[l] + LZ_W'(4);
      end else begin
        norm_step[l] = norm_r[l] << 1;
        lz_step[l]   = lz_r[l] + LZ_W'(1);
      end
      y_init[l] = Y_W'({1'b1, norm_r[l][SB-2 -: LOG_TABLE_BITS]}) << (30 - LOG_TABLE_BITS);
      sq[l]     = {31'd0, y_r[l]} * {31'd0, y_r[l]};
      yy[l]     = sq[l][61:30];
      neg[l]    = {lz_r[l], 16'd0} - {{LZ_W{1'b0}}, frac_r[l]};
    end
    if (zero_r[0]) begin
      neg_sel = neg[1];
    end else if (zero_r[1]) begin
      neg_sel = neg[0];
    end else begin
      neg_sel = (neg[0] <= neg[1]) ? neg[0] : neg[1];
    end
    rnd_sum = prod_r + PROD_W'(24'h80_0000);
    rounded = rnd_sum[PROD_W-1:24];
    if (silent_r || (32'(rounded) > 32'd32768)) begin
      mag = ONE_Q16 >> 1;
    end else begin
      mag = 17'(rounded);
    end
  end

  assign in_ready        = (state_r == F_IDLE);
  assign push_valid      = (state_r == F_PUSH);
  assign push_data.item  = item_r;
  assign push_data.level = 16'(17'd0 - mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            for (int l = 0; l < 2; l++) begin
              norm_r[l] <= abs_in[l];
              lz_r[l]   <= '0;
              zero_r[l] <= (abs_in[l] == '0);
            end
            state_r <= F_NORM;
          end
        end
        F_NORM: begin
          for (int l = 0; l < 2; l++) begin
            if (!lane_done[l]) begin
              norm_r[l] <= norm_step[l];
              lz_r[l]   <= lz_step[l];
            end
            y_r[l]    <= y_init[l];
            frac_r[l] <= '0;
          end
          cnt_r <= '0;
          if (&lane_done) begin
            state_r <= F_SQ;
          end
        end
        F_SQ: begin
          for (int l = 0; l < 2; l++) begin
            if (yy[l][31]) begin
              y_r[l]    <= yy[l][31:1];
              frac_r[l] <= {frac_r[l][14:0], 1'b1};
            end else begin
              y_r[l]    <= yy[l][30:0];
              frac_r[l] <= {frac_r[l][14:0], 1'b0};
            end
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prod_r   <= PROD_W'(neg_sel) * PROD_W'(DB_PER_LOG2);
          silent_r <= &zero_r;
          state_r  <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/skc_queue.sv]
`default_nettype none
module skc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  skc_pkg::q_item_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output skc_pkg::q_item_t pop_data
);
  import skc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_item_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != (PTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/skc_back.sv]
`default_nettype none
module skc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  skc_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  skc_pkg::q_item_t   pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output skc_pkg::out_item_t out_data
);
  import skc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 32;
  localparam logic [PW-1:0] MAX_POS = PW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [PW-1:0] MAX_NEG = PW'(64'd1 << (SB - 1));

  typedef enum logic [3:0] {
    B_IDLE, B_CLASS, B_HARD, B_SQ, B_KS, B_SL1, B_SL2,
    B_BL1, B_BL2, B_SM1, B_SM2, B_EXP, B_LIN, B_MUL, B_OUT
  } state_t;

  function automatic logic signed [15:0] sat_neg(input logic [31:0] m);
    return (m > 32'd32768) ? 16'sh8000 : 16'(32'd0 - m);
  endfunction

  function automatic logic [SB-1:0] sat_out(input logic [PW-1:0] m, input logic sgn);
    logic [PW-1:0] c;
    if (sgn) begin
      c = (m > MAX_NEG) ? MAX_NEG : m;
      return SB'(PW'(0) - c);
    end
    c = (m > MAX_POS) ? MAX_POS : m;
    return c[SB-1:0];
  endfunction

  state_t              state_r;
  in_item_t            item_r;
  logic signed [15:0]  level_r;
  logic signed [17:0]  d_r;
  logic [14:0]         x2_r;
  logic                gated_r;
  logic signed [15:0]  gc_r;
  logic signed [34:0]  acc_r;
  logic [29:0]         sq_r;
  logic [45:0]         a46_r;
  logic [39:0]         pl_r;
  logic [16:0]         alpha_r;
  logic signed [15:0]  smoothed_r;
  logic signed [5:0]   n_r;
  logic [15:0]         f_r;
  logic [31:0]         lin_r;
  logic [3:0]          k_r;
  logic [PW-1:0]       prod_l_r;
  logic [PW-1:0]       prod_r_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [16:0]         slope;
  logic signed [17:0]  d;
  logic signed [18:0]  e2;
  logic signed [18:0]  w19;
  logic signed [18:0]  x2;
  logic [33:0]         hard_prod;
  logic [39:0]         ph;
  logic [63:0]         soft_total;
  logic signed [34:0]  blend_sum;
  logic signed [34:0]  smooth_sum;
  logic signed [15:0]  gb;
  logic signed [30:0]  t;
  logic [63:0]         lin_prod;
  logic signed [6:0]   sh_s;
  logic [5:0]          sh;
  logic                out_free;

  always_comb begin
    slope      = ONE_Q16 - cfg.inv_ratio;
    d          = 18'(level_r) - 18'(cfg.threshold_db);
    e2         = 19'(d) <<< 1;
    w19        = $signed({5'd0, cfg.knee_width_db});
    x2         = e2 + w19;
    hard_prod  = {17'd0, d_r[16:0]} * {17'd0, slope};
    ph         = {17'd0, a46_r[45:23]} * {23'd0, slope};
    soft_total = {1'b0, ph, 23'd0} + {24'd0, pl_r};
    blend_sum  = acc_r + $signed({1'b0, cfg.coupling_weight}) * item_r.coupling_gain_db;
    gb         = blend_sum[31:16];
    smooth_sum = acc_r + $signed({1'b0, ONE_Q16 - alpha_r}) * gc_r;
    t          = smoothed_r * $signed({1'b0, LOG2_PER_DB});
    lin_prod   = {32'd0, lin_r} * {32'd0, ROOTS[k_r]};
    sh_s       = 7'sd30 - 7'(n_r);
    sh         = sh_s[5:0];
    out_free   = !out_valid_r || out_ready;
  end

  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      smoothed_r  <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            item_r  <= pop_data.item;
            level_r <= pop_data.level;
            state_r <= B_CLASS;
          end
        end
        B_CLASS: begin
          d_r     <= d;
          x2_r    <= x2[14:0];
          gated_r <= (level_r < cfg.gate_threshold_db);
          if ((cfg.knee_width_db == '0) || (e2 > w19)) begin
            if (d < 0) begin
              gc_r    <= '0;
              state_r <= B_BL1;
            end else begin
              state_r <= B_HARD;
            end
          end else if (e2 < -w19) begin
            gc_r    <= '0;
            state_r <= B_BL1;
          end else begin
            state_r <= B_SQ;
          end
        end
        B_HARD: begin
          gc_r    <= sat_neg(32'(hard_prod[33:16]));
          state_r <= B_BL1;
        end
        B_SQ: begin
          sq_r    <= {15'd0, x2_r} * {15'd0, x2_r};
          state_r <= B_KS;
        end
        B_KS: begin
          a46_r   <= {16'd0, sq_r} * {30'd0, cfg.knee_scale};
          state_r <= B_SL1;
        end
        B_SL1: begin
          pl_r    <= {17'd0, a46_r[22:0]} * {23'd0, slope};
          state_r <= B_SL2;
        end
        B_SL2: begin
          gc_r    <= sat_neg(32'(soft_total[63:38]));
          state_r <= B_BL1;
        end
        B_BL1: begin
          acc_r   <= $signed({1'b0, ONE_Q16 - cfg.coupling_weight}) * gc_r;
          state_r <= B_BL2;
        end
        B_BL2: begin
          gc_r <= gb;
          if (gated_r) begin
            state_r <= B_EXP;
          end else begin
            alpha_r <= (gb <= smoothed_r) ? {1'b0, cfg.attack_coef} : {1'b0, cfg.release_coef};
            state_r <= B_SM1;
          end
        end
        B_SM1: begin
          acc_r   <= $signed({1'b0, alpha_r}) * smoothed_r;
          state_r <= B_SM2;
        end
        B_SM2: begin
          smoothed_r <= smooth_sum[31:16];
          state_r    <= B_EXP;
        end
        B_EXP: begin
          n_r     <= t[29:24];
          f_r     <= t[23:8];
          lin_r   <= 32'h4000_0000;
          k_r     <= '0;
          state_r <= B_LIN;
        end
        B_LIN: begin
          if (f_r[4'd15 - k_r]) begin
            lin_r <= lin_prod[61:30];
          end
          k_r <= k_r + 4'd1;
          if (k_r == 4'd15) begin
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_l_r <= PW'(abs_sample(item_r.left_sample)) * PW'(lin_r);
          prod_r_r <= PW'(abs_sample(item_r.right_sample)) * PW'(lin_r);
          state_r  <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_data_r.out_left  <= sat_out(prod_l_r >> sh, item_r.left_sample[SB-1]);
            out_data_r.out_right <= sat_out(prod_r_r >> sh, item_r.right_sample[SB-1]);
            out_data_r.gain_db   <= smoothed_r;
            out_data_r.gated     <= gated_r;
            state_r              <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/stereo_soft_knee_compressor.sv]
`default_nettype none
// Front (level detection): a normalise phase, 16 squaring steps of the log unit, then multiply and push.
// Back (gain path): 16 of its steps are in the root-product loop of the gain unit.
// Front and back each take a new transaction only when idle; the queue between them lets the front run ahead.
// Synchronous active-low reset: registers to defaults, smoothed gain to -10 dB, queue empty.
module stereo_soft_knee_compressor #(
  parameter int LOG_TABLE_BITS = skc_pkg::LOG_TABLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  skc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output skc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import skc_pkg::*;

  cfg_t        cfg_r;
  logic [16:0] clamped;
  logic        push_valid;
  logic        push_ready;
  q_item_t     push_data;
  logic        pop_valid;
  logic        pop_ready;
  q_item_t     pop_data;

  assign cfg_ready = 1'b1;
  assign clamped   = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_db      <= THRESHOLD_RESET;
      cfg_r.gate_threshold_db <= GATE_RESET;
      cfg_r.inv_ratio         <= INV_RATIO_RESET;
      cfg_r.knee_width_db     <= '0;
      cfg_r.knee_scale        <= '0;
      cfg_r.attack_coef       <= '0;
      cfg_r.release_coef      <= '0;
      cfg_r.coupling_weight   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        REG_THRESHOLD:  cfg_r.threshold_db      <= cfg_data[15:0];
        REG_GATE:       cfg_r.gate_threshold_db <= cfg_data[15:0];
        REG_INV_RATIO:  cfg_r.inv_ratio         <= clamped;
        REG_KNEE_WIDTH: cfg_r.knee_width_db     <= cfg_data[13:0];
        REG_KNEE_SCALE: cfg_r.knee_scale        <= cfg_data[15:0];
        REG_ATTACK:     cfg_r.attack_coef       <= cfg_data[15:0];
        REG_RELEASE:    cfg_r.release_coef      <= cfg_data[15:0];
        REG_COUPLING:   cfg_r.coupling_weight   <= clamped;
        default: ;
      endcase
    end
  end

  skc_front #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  skc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  skc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front took a second transaction while busy");

  a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> !pop_ready)
    else $error("back popped while busy");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
    else $error("front dropped or changed a stalled level");

endmodule
`default_nettype wire
